// ----- hw/rtl/key_debounce_hold_event_queue_defines.svh -----
// ----------------------------------------------------------------------------
// Key debounce event queue - assertion macros
// Concurrent check wrappers on clk / arst_n; empty in synthesis builds.
// ----------------------------------------------------------------------------
`ifndef KEY_DEBOUNCE_HOLD_EVENT_QUEUE_DEFINES_SVH
`define KEY_DEBOUNCE_HOLD_EVENT_QUEUE_DEFINES_SVH

`ifndef SYNTHESIS
// same-cycle implication
`define KDQ_ASSERT_IMP(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);
// next-cycle implication
`define KDQ_ASSERT_NXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);
`else
`define KDQ_ASSERT_IMP(lbl, ante, cons, msg)
`define KDQ_ASSERT_NXT(lbl, ante, cons, msg)
`endif

`endif

// ----- hw/rtl/kdq_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kdq_pkg
// Shared types and constants of the key debounce event queue.
// ----------------------------------------------------------------------------
package kdq_pkg;

	typedef logic [1:0] kind_t;

	localparam kind_t KIND_PRESS   = 2'd0;
	localparam kind_t KIND_RELEASE = 2'd1;
	localparam kind_t KIND_HOLD    = 2'd2;

	localparam logic OP_TICK = 1'b0;
	localparam logic OP_POP  = 1'b1;

	localparam logic CFG_DEBOUNCE = 1'b0;
	localparam logic CFG_HOLD     = 1'b1;

	localparam logic [15:0] DEBOUNCE_RESET = 16'd20;
	localparam logic [15:0] HOLD_RESET     = 16'd500;

	// one queued event
	typedef struct packed {
		kind_t      kind;
		logic [2:0] key;
	} event_t;

	typedef struct packed {
		logic push;
		logic pop;
	} fifo_req_t;

	typedef struct packed {
		logic full;
		logic empty;
	} fifo_stat_t;

	typedef struct packed {
		logic deb_ok;
		logic hold_ok;
	} age_flags_t;

endpackage

// ----- hw/rtl/key_debounce_hold_event_queue.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// key_debounce_hold_event_queue
// Active-low key debouncer with press / release / hold events in a FIFO.
// ----------------------------------------------------------------------------
//  channel | handshake            | payload
//  --------+----------------------+-------------------------------------------
//  in      | in_valid / in_stall  | operation, now_time, key_levels
//  out     | out_valid / out_stall| event_valid, event_kind, event_key,
//          |                      | pressed_mask, queue_fill, dropped
//  cfg     | cfg_valid / cfg_ready| cfg_index, cfg_data
//
//  Tick item: one key per cycle through the shared age unit.
//  Pop item: the read of the event memory is registered, then loaded into out.
//  One item at a time; a new item is taken while the last result waits on out.
//  A finished item parks in emit until the output register is free.
//  Reset clears key state, pointers and fill count; event memory is not cleared.
// ----------------------------------------------------------------------------
`include "key_debounce_hold_event_queue_defines.svh"

module key_debounce_hold_event_queue
	import kdq_pkg::*;
#(
	parameter int KEY_COUNT   = 8,
	parameter int QUEUE_DEPTH = 16
) (
	input  logic        clk,
	input  logic        arst_n,

	input  logic        in_valid,
	output logic        in_stall,
	input  logic        operation,
	input  logic [31:0] now_time,
	input  logic [7:0]  key_levels,

	output logic        out_valid,
	input  logic        out_stall,
	output logic        event_valid,
	output logic [1:0]  event_kind,
	output logic [2:0]  event_key,
	output logic [7:0]  pressed_mask,
	output logic [4:0]  queue_fill,
	output logic        dropped,

	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic        cfg_index,
	input  logic [15:0] cfg_data
);

	localparam int KEY_W  = (KEY_COUNT > 1) ? $clog2(KEY_COUNT) : 1;
	localparam int FILL_W = $clog2(QUEUE_DEPTH + 1);
	localparam logic [KEY_W-1:0] LAST_KEY = KEY_W'(KEY_COUNT - 1);

	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_SCAN = 2'd1;
	localparam logic [1:0] ST_EMIT = 2'd2;

	logic [1:0]       state_q;
	logic [KEY_W-1:0] key_idx_q;
	logic [31:0]      now_q;
	logic [7:0]       levels_q;
	logic             ev_valid_q;
	logic             drop_q;
	logic [15:0]      debounce_q;
	logic [15:0]      hold_q;

	logic [KEY_COUNT-1:0] raw_last_q;
	logic [KEY_COUNT-1:0] debounced_q;
	logic [KEY_COUNT-1:0] hold_sent_q;
	logic [31:0]          change_time_q [KEY_COUNT];

	logic                 in_accept;
	logic                 scan;
	logic                 out_load;
	logic [KEY_COUNT-1:0] pressed_vec;
	logic [7:0]           mask8;
	logic                 cur_pressed;
	logic                 cur_deb;
	logic                 changed;
	logic                 push;
	kind_t                push_kind;
	age_flags_t           flags;
	fifo_req_t            fifo_req;
	fifo_stat_t           fifo_stat;
	event_t               wr_event;
	event_t               rd_event;
	logic [FILL_W-1:0]    fill_cnt;

	logic        out_valid_q;
	logic        event_valid_q;
	kind_t       event_kind_q;
	logic [2:0]  event_key_q;
	logic [7:0]  pressed_mask_q;
	logic [4:0]  queue_fill_q;
	logic        dropped_q;

	assign in_stall  = (state_q != ST_IDLE);
	assign in_accept = in_valid && !in_stall;
	assign cfg_ready = 1'b1;
	assign scan      = (state_q == ST_SCAN);
	assign out_load  = (state_q == ST_EMIT) && (!out_valid_q || !out_stall);

	// keys without a level bit read as released
	for (genvar i = 0; i < KEY_COUNT; i++) begin : g_pressed
		if (i < 8) begin : g_pin
			assign pressed_vec[i] = ~levels_q[i];
		end else begin : g_none
			assign pressed_vec[i] = 1'b0;
		end
	end

	for (genvar i = 0; i < 8; i++) begin : g_mask
		if (i < KEY_COUNT) begin : g_key
			assign mask8[i] = debounced_q[i];
		end else begin : g_none
			assign mask8[i] = 1'b0;
		end
	end

	assign cur_pressed = pressed_vec[key_idx_q];
	assign cur_deb     = debounced_q[key_idx_q];
	assign changed     = (cur_pressed != raw_last_q[key_idx_q]);

	kdq_age_unit u_age (
		.now_time      (now_q),
		.change_time   (change_time_q[key_idx_q]),
		.debounce_time (debounce_q),
		.hold_time     (hold_q),
		.flags         (flags)
	);

	always_comb begin
		push      = 1'b0;
		push_kind = KIND_PRESS;
		if (scan && !changed && flags.deb_ok) begin
			if (cur_pressed && !cur_deb) begin
				push      = 1'b1;
				push_kind = KIND_PRESS;
			end else if (!cur_pressed && cur_deb) begin
				push      = 1'b1;
				push_kind = KIND_RELEASE;
			end else if (cur_pressed && cur_deb && !hold_sent_q[key_idx_q] &&
			             flags.hold_ok) begin
				push      = 1'b1;
				push_kind = KIND_HOLD;
			end
		end
	end

	assign fifo_req.push = push;
	assign fifo_req.pop  = in_accept && (operation == OP_POP) && !fifo_stat.empty;
	assign wr_event.kind = push_kind;
	assign wr_event.key  = 3'(key_idx_q);

	kdq_event_fifo #(
		.DEPTH (QUEUE_DEPTH)
	) u_fifo (
		.clk     (clk),
		.arst_n  (arst_n),
		.req     (fifo_req),
		.wr_data (wr_event),
		.rd_data (rd_event),
		.stat    (fifo_stat),
		.count   (fill_cnt)
	);

	// configuration
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			debounce_q <= DEBOUNCE_RESET;
			hold_q     <= HOLD_RESET;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				CFG_DEBOUNCE: debounce_q <= cfg_data;
				CFG_HOLD:     hold_q     <= cfg_data;
				default:      debounce_q <= debounce_q;
			endcase
		end
	end

	// per-key state, one key per scan cycle
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			raw_last_q  <= '0;
			debounced_q <= '0;
			hold_sent_q <= '0;
			for (int i = 0; i < KEY_COUNT; i++) begin
				change_time_q[i] <= '0;
			end
		end else if (scan) begin
			if (changed) begin
				change_time_q[key_idx_q] <= now_q;
				raw_last_q[key_idx_q]    <= cur_pressed;
			end else if (flags.deb_ok) begin
				debounced_q[key_idx_q] <= cur_pressed;
				if (cur_pressed != cur_deb) begin
					hold_sent_q[key_idx_q] <= 1'b0;
				end else if (push) begin
					hold_sent_q[key_idx_q] <= 1'b1;
				end
			end
		end
	end

	// sample latch
	always_ff @(posedge clk) begin
		if (in_accept) begin
			now_q    <= now_time;
			levels_q <= key_levels;
		end
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			key_idx_q  <= '0;
			ev_valid_q <= 1'b0;
			drop_q     <= 1'b0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (in_accept) begin
						key_idx_q <= '0;
						drop_q    <= 1'b0;
						if (operation == OP_TICK) begin
							ev_valid_q <= 1'b0;
							state_q    <= ST_SCAN;
						end else begin
							ev_valid_q <= !fifo_stat.empty;
							state_q    <= ST_EMIT;
						end
					end
				end
				ST_SCAN: begin
					if (push && fifo_stat.full) begin
						drop_q <= 1'b1;
					end
					if (key_idx_q == LAST_KEY) begin
						state_q <= ST_EMIT;
					end else begin
						key_idx_q <= key_idx_q + 1'b1;
					end
				end
				ST_EMIT: begin
					if (out_load) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			event_valid_q  <= ev_valid_q;
			event_kind_q   <= ev_valid_q ? rd_event.kind : KIND_PRESS;
			event_key_q    <= ev_valid_q ? rd_event.key : 3'd0;
			pressed_mask_q <= mask8;
			queue_fill_q   <= 5'(fill_cnt);
			dropped_q      <= drop_q;
		end
	end

	assign out_valid    = out_valid_q;
	assign event_valid  = event_valid_q;
	assign event_kind   = event_kind_q;
	assign event_key    = event_key_q;
	assign pressed_mask = pressed_mask_q;
	assign queue_fill   = queue_fill_q;
	assign dropped      = dropped_q;

	`KDQ_ASSERT_IMP(a_fill_bound, 1'b1, fill_cnt <= FILL_W'(QUEUE_DEPTH), "queue fill above depth")
	`KDQ_ASSERT_NXT(a_tick_start, in_accept && (operation == OP_TICK), (state_q == ST_SCAN) && (key_idx_q == '0), "tick did not start scan at key zero")
	`KDQ_ASSERT_NXT(a_drop_full, fifo_req.push && fifo_stat.full, $stable(fill_cnt) && drop_q, "event into full queue not flagged")
	`KDQ_ASSERT_NXT(a_emit_load, out_load, out_valid_q && (state_q == ST_IDLE), "result load did not free the sequencer")

endmodule

// ----- hw/rtl/kdq_age_unit.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kdq_age_unit
// Shared timer unit: age of the visited key and its two threshold compares.
// ----------------------------------------------------------------------------
module kdq_age_unit
	import kdq_pkg::*;
(
	input  logic [31:0] now_time,
	input  logic [31:0] change_time,
	input  logic [15:0] debounce_time,
	input  logic [15:0] hold_time,
	output age_flags_t  flags
);

	logic [31:0] age;

	// wraps modulo 2^32
	assign age = now_time - change_time;

	assign flags.deb_ok  = (age >= {16'd0, debounce_time});
	assign flags.hold_ok = (age >= {16'd0, hold_time});

endmodule

// ----- hw/rtl/kdq_event_fifo.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kdq_event_fifo
// Event queue: memory with registered read, wrap pointers and fill count.
// ----------------------------------------------------------------------------
module kdq_event_fifo
	import kdq_pkg::*;
#(
	parameter int DEPTH = 16
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  fifo_req_t                    req,
	input  event_t                       wr_data,
	output event_t                       rd_data,
	output fifo_stat_t                   stat,
	output logic [$clog2(DEPTH+1)-1:0]   count
);

	localparam int PTR_W = $clog2(DEPTH);
	localparam int CNT_W = $clog2(DEPTH + 1);
	localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
	localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

	event_t           mem [DEPTH];
	event_t           rd_data_q;
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;
	logic             push_ok;
	logic             pop_ok;

	assign stat.full  = (count_q == FULL_CNT);
	assign stat.empty = (count_q == '0);
	assign push_ok    = req.push && !stat.full;
	assign pop_ok     = req.pop && !stat.empty;
	assign count      = count_q;
	assign rd_data    = rd_data_q;

	always_ff @(posedge clk) begin
		if (push_ok) begin
			mem[wr_ptr_q] <= wr_data;
		end
	end

	always_ff @(posedge clk) begin
		if (pop_ok) begin
			rd_data_q <= mem[rd_ptr_q];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push_ok) begin
				wr_ptr_q <= (wr_ptr_q == LAST_PTR) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop_ok) begin
				rd_ptr_q <= (rd_ptr_q == LAST_PTR) ? '0 : rd_ptr_q + 1'b1;
			end
			case ({push_ok, pop_ok})
				2'b10:   count_q <= count_q + 1'b1;
				2'b01:   count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end

endmodule
